// ===== rtl/grmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_pkg : shared types and constants for the grid ray march column core
// Register indexes, defaults, sine table generation and the control state.
// ----------------------------------------------------------------------------
package grmc_pkg;

  localparam int unsigned MapSizeDef   = 32;
  localparam int unsigned MarchStepDef = 20;
  localparam int unsigned SineDepthDef = 256;

  localparam logic [2:0] RegPlayerX  = 3'd0;
  localparam logic [2:0] RegPlayerY  = 3'd1;
  localparam logic [2:0] RegView     = 3'd2;
  localparam logic [2:0] RegFov      = 3'd3;
  localparam logic [2:0] RegMaxDepth = 3'd4;
  localparam logic [2:0] RegColumns  = 3'd5;
  localparam logic [2:0] RegRows     = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV1,
    ST_ANGLE,
    ST_SIN,
    ST_STEP,
    ST_RDMAP,
    ST_TEST,
    ST_CEIL_MUL,
    ST_DIV2,
    ST_OUT
  } state_e;

  // Quarter-wave polynomial, r in 0..16384, result Q14.
  function automatic logic [15:0] quarter_wave(input logic [14:0] r);
    logic [31:0] x, x2, t;
    begin
      x  = {16'd0, r, 1'b0};
      x2 = (x * x) >> 15;
      t  = 32'd153 - ((x2 * 32'd5) >> 15);
      t  = 32'd2611 - ((x2 * t) >> 15);
      t  = 32'd21167 - ((x2 * t) >> 15);
      t  = 32'd51472 - ((x2 * t) >> 15);
      x  = (((x * t) >> 15) + 32'd1) >> 1;
      quarter_wave = x[15:0];
    end
  endfunction

  function automatic logic signed [15:0] sine_q14(input logic [15:0] a);
    logic [14:0] r;
    logic [15:0] v;
    begin
      r = {1'b0, a[13:0]};
      if (a[14]) r = 15'd16384 - r;
      v = quarter_wave(r);
      sine_q14 = a[15] ? -$signed(v) : $signed(v);
    end
  endfunction

endpackage

// ===== rtl/grmc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_divider : restoring unsigned divider, one quotient bit per cycle
// Shared by the ray angle and the ceiling row calculations.
// ----------------------------------------------------------------------------
module grmc_divider #(
  parameter int unsigned W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [W-1:0]          num_i,
  input  logic [W-1:0]          den_i,
  output logic                  busy_o,
  output logic [W-1:0]          quo_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W:0]    trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    cnt_d = cnt_q;
    trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
      cnt_d = CW'(W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

`ifndef ASSERT_OFF
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_o) else $error("divider not busy after start");
  a_count_falls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_o && !start_i) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("divider count skipped");
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !start_i) |=> !busy_o) else $error("divider woke alone");
`endif
endmodule

// ===== rtl/grmc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grmc_ram : generic single-port RAM with registered read
// One write or read address per cycle.
// ----------------------------------------------------------------------------
module grmc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/grid_ray_march_column_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_march_column_core : fixed-step grid raycaster, one column per cast
// ----------------------------------------------------------------------------
// A map row load is taken in the idle state, but not during the clearing pass
// that follows reset, when no item is taken. A cast runs two divisions plus
// setup and output, and each march step passes through the step, map read and
// test states. With default settings and an open path to max depth the march
// runs 1639 steps.
// The march loop with its single map read port dominates the cast. The result
// sits in an output register; the next item is taken while it waits, and a
// cast that finishes before that result has been transferred holds in its
// last state until it is.
// ----------------------------------------------------------------------------
module grid_ray_march_column_core #(
  parameter int unsigned MAP_SIZE         = grmc_pkg::MapSizeDef,
  parameter int unsigned MARCH_STEP       = grmc_pkg::MarchStepDef,
  parameter int unsigned SINE_TABLE_DEPTH = grmc_pkg::SineDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [4:0]         row_index_i,
  input  logic [31:0]        row_bits_i,
  input  logic [9:0]         column_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [9:0]         column_out_o,
  output logic [15:0]        distance_o,
  output logic               wall_hit_o,
  output logic signed [10:0] ceiling_row_o,
  output logic [10:0]        floor_row_o,
  output logic [10:0]        texture_u_o
);
  import grmc_pkg::*;

  localparam int unsigned AW = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
  localparam int unsigned SW = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DW = 32;

  // configuration
  logic [15:0] px_q, py_q, view_q, maxd_q;
  logic [14:0] fov_q;
  logic [9:0]  cols_q;
  logic [8:0]  rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= 16'd16384; py_q <= 16'd16384; view_q <= 16'd49152;
      fov_q <= 15'd8192; maxd_q <= 16'd32768; cols_q <= 10'd300; rows_q <= 9'd160;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegPlayerX:  px_q   <= cfg_data_i;
        RegPlayerY:  py_q   <= cfg_data_i;
        RegView:     view_q <= cfg_data_i;
        RegFov:      fov_q  <= cfg_data_i[14:0];
        RegMaxDepth: maxd_q <= cfg_data_i;
        RegColumns:  cols_q <= cfg_data_i[9:0];
        RegRows:     rows_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic [AW:0]  clr_q, clr_d;
  logic         clr_busy;
  logic [9:0]   col_q, col_d;
  logic [15:0]  ray_q, ray_d;
  logic signed [15:0] ex_q, ex_d, ey_q, ey_d;
  logic [16:0]  dist_q, dist_d;
  logic signed [40:0] sx_q, sx_d, sy_q, sy_d;
  logic         hit_q, hit_d, sin_sel_q, sin_sel_d;
  logic [10:0]  tex_q, tex_d;
  logic         neg_q, neg_d;
  logic signed [10:0] ceil_q, ceil_d;

  // output register
  logic [9:0]  o_col_q, o_col_d;
  logic [15:0] o_dist_q, o_dist_d;
  logic        o_hit_q, o_hit_d;
  logic signed [10:0] o_ceil_q, o_ceil_d;
  logic [10:0] o_tex_q, o_tex_d;

  // shared divider
  logic          div_start, div_busy;
  logic [DW-1:0] dnum, dden, dquo;
  grmc_divider #(.W(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(dnum), .den_i(dden),
    .busy_o(div_busy), .quo_o(dquo)
  );

  // map memory
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;
  grmc_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_map (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata), .rdata_o(ram_rdata)
  );

  // constant sine table, entry q at angle q*65536/depth
  logic signed [15:0] sine_lut [SINE_TABLE_DEPTH];
  for (genvar g = 0; g < int'(SINE_TABLE_DEPTH); g++) begin : g_sine
    assign sine_lut[g] = sine_q14(16'((g * 65536) / SINE_TABLE_DEPTH));
  end

  // march test point cells
  logic [15:0] cxw, cyw;
  logic        out_map;
  logic [AW-1:0] cx_a, cy_a;
  logic signed [16:0] dxo, dyo;
  logic        use_y;
  logic [31:0] sin_prod;
  logic [16:0] ang_sum;
  logic [SW-1:0] qidx, qidx_c;
  logic [16:0] dist_sat;
  logic signed [17:0] dm;
  logic [16:0] dm_abs;

  assign clr_busy = (clr_q != '0);
  assign sin_prod = {17'd0, fov_q} * {22'd0, column_i};

  always_comb begin
    cxw  = 16'(sx_q >>> 25);
    cyw  = 16'(sy_q >>> 25);
    out_map = sx_q[40] || sy_q[40] || (cxw >= 16'(MAP_SIZE)) || (cyw >= 16'(MAP_SIZE));
    cx_a = cxw[AW-1:0];
    cy_a = cyw[AW-1:0];
    dxo  = $signed(17'(sx_q[24:14])) - 17'sd1024;
    dyo  = $signed(17'(sy_q[24:14])) - 17'sd1024;
    use_y = (dxo == 0 && dyo == 0) || (dxo > 0 && -dxo <= dyo && dyo < dxo) ||
            (dxo < 0 && dxo < dyo && dyo <= -dxo);
    ang_sum = {1'b0, view_q} - 17'(fov_q >> 1) + 17'(dquo[15:0]);
    qidx   = SW'(ray_q >> (16 - SW));
    qidx_c = qidx + SW'(SINE_TABLE_DEPTH / 4);
    dist_sat = (dist_q > 17'd65535) ? 17'd65535 : dist_q;
    dm = $signed({1'b0, dist_sat}) - 18'sd4096;
    dm_abs = dm[17] ? 17'(-dm) : 17'(dm);
  end

  always_comb begin
    state_d = state_q; clr_d = clr_q; col_d = col_q; ray_d = ray_q;
    ex_d = ex_q; ey_d = ey_q; dist_d = dist_q; sx_d = sx_q; sy_d = sy_q;
    hit_d = hit_q; tex_d = tex_q; sin_sel_d = sin_sel_q; neg_d = neg_q;
    ceil_d = ceil_q;
    o_col_d = o_col_q; o_dist_d = o_dist_q; o_hit_d = o_hit_q;
    o_ceil_d = o_ceil_q; o_tex_d = o_tex_q;
    div_start = 1'b0; dnum = '0; dden = 32'd1;
    ram_we = 1'b0; ram_addr = '0; ram_wdata = '0;
    in_ready_o = 1'b0;
    if (clr_busy) begin
      ram_we = 1'b1; ram_addr = AW'(clr_q - 1'b1); clr_d = clr_q - 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = !clr_busy;
        if (in_valid_i && in_ready_o) begin
          if (!kind_i) begin
            ram_we = ({1'b0, row_index_i} < 6'(MAP_SIZE));
            ram_addr = AW'(row_index_i);
            ram_wdata = row_bits_i;
          end else begin
            col_d = column_i;
            div_start = 1'b1; dnum = sin_prod;
            dden = (cols_q == '0) ? 32'd1 : {22'd0, cols_q};
            state_d = ST_DIV1;
          end
        end
      end
      ST_DIV1: if (!div_busy && !div_start) state_d = ST_ANGLE;
      ST_ANGLE: begin
        ray_d = ang_sum[15:0]; sin_sel_d = 1'b0; state_d = ST_SIN;
      end
      ST_SIN: begin
        if (!sin_sel_q) begin
          ex_d = sine_lut[qidx]; sin_sel_d = 1'b1;
        end else begin
          ey_d = sine_lut[qidx_c];
          dist_d = '0; hit_d = 1'b0; tex_d = '0;
          sx_d = $signed({25'd0, px_q}) <<< 14;
          sy_d = $signed({25'd0, py_q}) <<< 14;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (dist_q >= {1'b0, maxd_q}) begin
          state_d = ST_CEIL_MUL;
        end else begin
          dist_d = dist_q + 17'(MARCH_STEP);
          sx_d = sx_q + 41'(ex_q) * 41'(MARCH_STEP);
          sy_d = sy_q + 41'(ey_q) * 41'(MARCH_STEP);
          state_d = ST_RDMAP;
        end
      end
      ST_RDMAP: begin
        ram_addr = cy_a;
        state_d = ST_TEST;
      end
      ST_TEST: begin
        if (out_map) begin
          dist_d = {1'b0, maxd_q}; state_d = ST_CEIL_MUL;
        end else if ((cxw < 16'd32) && ram_rdata[cx_a[4:0] & 5'h1f]) begin
          hit_d = 1'b1;
          tex_d = use_y ? sy_q[24:14] : sx_q[24:14];
          state_d = ST_CEIL_MUL;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_CEIL_MUL: begin
        if (dist_sat == '0) begin
          ceil_d = -11'sd1024; state_d = ST_OUT;
        end else begin
          neg_d = dm[17];
          div_start = 1'b1;
          dnum = {23'd0, rows_q} * {15'd0, dm_abs};
          dden = {14'd0, dist_sat, 1'b0};
          state_d = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (!div_busy && !div_start) begin
          if (neg_d) ceil_d = (dquo > 32'd1024) ? -11'sd1024 : 11'(-$signed({1'b0, dquo[10:0]}));
          else       ceil_d = (dquo > 32'd1023) ? 11'sd1023 : $signed(dquo[10:0]);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_o || out_ready_i) begin
          o_col_d = col_q; o_dist_d = dist_sat[15:0]; o_hit_d = hit_q;
          o_ceil_d = ceil_q; o_tex_d = hit_q ? tex_q : '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  logic ov_set;
  assign ov_set = (state_q == ST_OUT) && (!out_valid_o || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      clr_q <= (AW + 1)'(MAP_SIZE);
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      if (ov_set) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d; ray_q <= ray_d; ex_q <= ex_d; ey_q <= ey_d;
    dist_q <= dist_d; sx_q <= sx_d; sy_q <= sy_d; hit_q <= hit_d; tex_q <= tex_d;
    sin_sel_q <= sin_sel_d; neg_q <= neg_d; ceil_q <= ceil_d;
    o_col_q <= o_col_d; o_dist_q <= o_dist_d; o_hit_q <= o_hit_d;
    o_ceil_q <= o_ceil_d; o_tex_q <= o_tex_d;
  end

  assign column_out_o  = o_col_q;
  assign distance_o    = o_dist_q;
  assign wall_hit_o    = o_hit_q;
  assign ceiling_row_o = o_ceil_q;
  assign floor_row_o   = 11'({2'b00, rows_q} - o_ceil_q);
  assign texture_u_o   = o_tex_q;

`ifndef ASSERT_OFF
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o) else $error("item taken mid cast");
  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_ready_o) else $error("item taken while clearing");
  a_out_after_cast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |=> out_valid_o) else $error("result lost");
  a_tex_zero_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !wall_hit_o) |-> (texture_u_o == '0)) else $error("texture on miss");
`endif
endmodule
